// File: hdl/ssa_pkg.sv
// Package for the sample slip accumulator: opcodes, register indexes,
// controller states, widths and constant tables. No dependencies.
package ssa_pkg;

    localparam int OP_W     = 2;
    localparam int PPM_W    = 16;
    localparam int BLOCK_W  = 10;
    localparam int CLAMP_W  = 4;
    localparam int ADJ_W    = 2;
    localparam int FRAC_W   = 21;
    localparam int SUM_W    = 27;
    localparam int MAG_W    = 24;
    localparam int QUOT_W   = 4;
    localparam int CNT_W    = 4;
    localparam int WHOLE_W  = 6;
    localparam int CFG_W    = 10;
    localparam int OUT_W    = 24;

    localparam logic [OP_W-1:0] OP_APPLY   = 2'd0;
    localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic REG_BLOCK_SAMPLES = 1'b0;
    localparam logic REG_CLAMP_SAMPLES = 1'b1;

    localparam logic [BLOCK_W-1:0] BLOCK_RESET = 10'd480;
    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 4'd10;

    localparam logic [MAG_W-1:0] ONE_SAMPLE = 24'd1000000;

    // Saturation limit in 1e-6 sample units for each clamp setting.
    localparam logic [MAG_W-1:0] LIMIT_TAB [16] = '{
        24'd0,        24'd1000000,  24'd2000000,  24'd3000000,
        24'd4000000,  24'd5000000,  24'd6000000,  24'd7000000,
        24'd8000000,  24'd9000000,  24'd10000000, 24'd11000000,
        24'd12000000, 24'd13000000, 24'd14000000, 24'd15000000
    };

    // Restoring-division trial values, one per quotient bit.
    localparam logic [MAG_W-1:0] STEP_TAB [4] = '{
        24'd1000000, 24'd2000000, 24'd4000000, 24'd8000000
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CLAMP,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

// File: hdl/sample_slip_accumulator.sv
// Sample slip accumulator top level: bit-serial scaling, clamp and
// digit-serial whole-sample extraction with an output register.
// Depends on ssa_pkg.
//
// Usage:
//   Input channel s_*: s_tuser carries the opcode (apply, consume, clear),
//   s_tdata the signed ppm correction. One item is taken at a time.
//   Output channel m_*: one result per item, the staged adjustment and the
//   accumulator remainder, held in an output register until taken.
//   Configuration: cfg_we with cfg_addr 0 writes block_samples, cfg_addr 1
//   writes clamp_samples; write only while the block is idle.
// Sequence:
//   Apply runs from accept to m_tvalid through the shift-add multiplier
//   (one block_samples bit per cycle), the clamp, the restoring division
//   (one quotient bit each), the fold of the whole samples into the staged
//   adjustment and the load of the output register. Consume, clear and
//   the unused opcode go straight to the output register load.
//   A new item is accepted in the cycle after the result is loaded, so
//   no item is taken while another is still in progress.
// Reset: both stores clear, registers return to 480 and 10.
// Stall: a waiting result stays in the output register; a finished next
//   result holds in ST_DONE until the output register frees up.
module sample_slip_accumulator
    import ssa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [PPM_W-1:0]    s_tdata,   // [15:0] ppm_offset
    input  logic [OP_W-1:0]     s_tuser,   // [1:0] opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // [1:0] adjust, [22:2] residue, [23] zero
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [CFG_W-1:0]    cfg_data
);

    state_t state_reg, state_next;

    logic [BLOCK_W-1:0]        block_reg;
    logic [CLAMP_W-1:0]        clamp_reg;
    logic signed [FRAC_W-1:0]  acc_reg, acc_next;
    logic signed [ADJ_W-1:0]   staged_reg, staged_next;

    logic signed [SUM_W-1:0]   prod_reg, prod_next;
    logic signed [SUM_W-1:0]   mcand_reg, mcand_next;
    logic [BLOCK_W-1:0]        mult_reg, mult_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic                      neg_reg, neg_next;
    logic [QUOT_W-1:0]         quot_reg, quot_next;
    logic signed [ADJ_W-1:0]   res_adj_reg, res_adj_next;
    logic signed [FRAC_W-1:0]  res_frac_reg, res_frac_next;

    logic                      out_valid_reg;
    logic [OUT_W-1:0]          out_data_reg;

    logic                      in_take;
    logic                      out_load;

    // Datapath temporaries
    logic [SUM_W-1:0]          prod_abs;
    logic [SUM_W-1:0]          limit_ext;
    logic [SUM_W-1:0]          clamped;
    logic [MAG_W-1:0]          step_val;
    logic                      step_ge;
    logic signed [WHOLE_W-1:0] whole;
    logic signed [WHOLE_W-1:0] pend;
    logic [FRAC_W-1:0]         frac_mag;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == OP_APPLY) ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(BLOCK_W - 1))
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake controls
    // ---------------------------------------------------------------
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign in_take = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_comb
    begin
        acc_next      = acc_reg;
        staged_next   = staged_reg;
        prod_next     = prod_reg;
        mcand_next    = mcand_reg;
        mult_next     = mult_reg;
        cnt_next      = cnt_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        quot_next     = quot_reg;
        res_adj_next  = res_adj_reg;
        res_frac_next = res_frac_reg;

        // Magnitude clamp: the limit is symmetric, so clamp |sum|.
        prod_abs  = prod_reg[SUM_W-1] ? SUM_W'(-prod_reg) : SUM_W'(prod_reg);
        limit_ext = SUM_W'(LIMIT_TAB[clamp_reg]);
        clamped   = (prod_abs > limit_ext) ? limit_ext : prod_abs;

        // One quotient bit per cycle, most significant first.
        step_val = STEP_TAB[cnt_reg[1:0]];
        step_ge  = (mag_reg >= step_val);

        // Fold whole samples into the staged adjustment.
        whole    = neg_reg ? -WHOLE_W'({2'b00, quot_reg}) : WHOLE_W'({2'b00, quot_reg});
        pend     = WHOLE_W'(staged_reg) + whole;
        frac_mag = FRAC_W'(mag_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    prod_next  = SUM_W'(acc_reg);
                    mcand_next = SUM_W'($signed(s_tdata));
                    mult_next  = block_reg;
                    cnt_next   = '0;
                    quot_next  = '0;
                    case (s_tuser)
                        OP_APPLY:
                        begin
                            res_adj_next  = staged_reg;
                            res_frac_next = acc_reg;
                        end
                        OP_CONSUME:
                        begin
                            res_adj_next  = staged_reg;
                            res_frac_next = acc_reg;
                            staged_next   = '0;
                        end
                        OP_CLEAR:
                        begin
                            res_adj_next  = '0;
                            res_frac_next = '0;
                            staged_next   = '0;
                            acc_next      = '0;
                        end
                        default:
                        begin
                            // unused opcode: report, change nothing
                            res_adj_next  = staged_reg;
                            res_frac_next = acc_reg;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                if (mult_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next = mcand_reg <<< 1;
                mult_next  = mult_reg >> 1;
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            ST_CLAMP:
            begin
                neg_next = prod_reg[SUM_W-1];
                mag_next = MAG_W'(clamped);
                cnt_next = CNT_W'(QUOT_W - 1);
            end
            ST_DIV:
            begin
                if (step_ge)
                begin
                    mag_next = mag_reg - step_val;
                end
                quot_next = {quot_reg[QUOT_W-2:0], step_ge};
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            ST_FIN:
            begin
                if (pend > WHOLE_W'(1))
                begin
                    staged_next = ADJ_W'(1);
                end
                else if (pend < -WHOLE_W'(1))
                begin
                    staged_next = -ADJ_W'(1);
                end
                else
                begin
                    staged_next = pend[ADJ_W-1:0];
                end
                acc_next      = neg_reg ? -frac_mag : frac_mag;
                res_adj_next  = staged_next;
                res_frac_next = acc_next;
            end
            default:
            begin
                // ST_DONE: hold
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers and stores
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            block_reg     <= BLOCK_RESET;
            clamp_reg     <= CLAMP_RESET;
            acc_reg       <= '0;
            staged_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            staged_reg <= staged_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_BLOCK_SAMPLES: block_reg <= cfg_data[BLOCK_W-1:0];
                    REG_CLAMP_SAMPLES: clamp_reg <= cfg_data[CLAMP_W-1:0];
                    default:           block_reg <= block_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        mcand_reg    <= mcand_next;
        mult_reg     <= mult_next;
        cnt_reg      <= cnt_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        quot_reg     <= quot_next;
        res_adj_reg  <= res_adj_next;
        res_frac_reg <= res_frac_next;
        if (out_load)
        begin
            out_data_reg <= {1'b0, res_frac_reg, res_adj_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Remainder of the division is always below one sample.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> mag_reg < ONE_SAMPLE)
        else $error("division remainder not below one sample");

    // The accumulator stays strictly within one sample.
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg < FRAC_W'(1000000)) && (acc_reg > -FRAC_W'(1000000)))
        else $error("accumulator outside one sample");

    // Staged adjustment never takes the code for -2.
    a_staged_code: assert property (@(posedge clk) disable iff (!rst_n)
        staged_reg != 2'b10)
        else $error("staged adjustment out of range");

    // An apply item always enters the multiplier next cycle.
    a_apply_mul: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_APPLY) |=> state_reg == ST_MUL)
        else $error("apply item did not start the multiplier");

endmodule
